// ----- rtl/sbsi_pkg.sv -----
package sbsi_pkg;

  // Control flags that travel with each axis through the divider pipeline.
  typedef struct packed {
    logic miss;      // span lies wholly outside the slab
    logic need_in;   // entry parameter is a real quotient (else 0)
    logic need_out;  // exit parameter is a real quotient (else 1.0)
  } axis_ctl_t;

endpackage

// ----- rtl/segment_box_slab_intersect.sv -----
// Segment versus axis-aligned box test in 2D by the slab method.
// Input channel: in_valid/in_ready with the segment end points and the box
// center and half extents. Result channel: out_valid/out_ready with out_hit
// and out_entry_t, the entry parameter in unsigned Q1.T_FRAC_BITS (zero on a
// miss). One result leaves for every transfer on the input, in order.
// Both axes are worked on side by side. Each axis forms its box bounds at
// widened precision, then feeds two pipelined restoring dividers that
// resolve one quotient bit per stage. A final stage merges the two
// intervals and decides hit or miss.
// Throughput is one item per cycle while the receiver keeps up; the divider
// depth sets the latency, not the rate.
// When the receiver stalls with a result waiting in the output stage, the
// whole pipeline freezes and in_ready drops; no item is lost or repeated.
// Reset clears all valid bits; the data stages need no reset.
module segment_box_slab_intersect #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_box_center_x,
  input  logic signed [COORD_BITS-1:0] in_box_center_y,
  input  logic [14:0]                  in_box_half_x,
  input  logic [14:0]                  in_box_half_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [T_FRAC_BITS:0]         out_entry_t
);

  // Axis stages (T_FRAC_BITS + 2) plus the merge stage.
  localparam int DEPTH = T_FRAC_BITS + 3;

  logic en;
  logic [DEPTH-1:0] vld_r;

  // The pipeline advances whenever the output stage is empty or drained.
  assign en       = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  sbsi_pkg::axis_ctl_t ctl_x, ctl_y;
  logic [T_FRAC_BITS:0] tin_x, tout_x, tin_y, tout_y;

  sbsi_axis #(.CB(COORD_BITS), .HB(15), .FRAC(T_FRAC_BITS)) u_axis_x (
    .clk(clk), .en(en), .s(in_start_x), .e(in_end_x), .c(in_box_center_x),
    .h(in_box_half_x), .ctl(ctl_x), .t_in(tin_x), .t_out(tout_x));
  sbsi_axis #(.CB(COORD_BITS), .HB(15), .FRAC(T_FRAC_BITS)) u_axis_y (
    .clk(clk), .en(en), .s(in_start_y), .e(in_end_y), .c(in_box_center_y),
    .h(in_box_half_y), .ctl(ctl_y), .t_in(tin_y), .t_out(tout_y));

  // Merge: the x axis narrows [0,1] first, then y narrows the result. Since
  // max and min commute, the final interval is the max of entries and min of
  // exits; an empty interval after x stays empty after y.
  logic [T_FRAC_BITS:0] lo, hi;
  logic hit_nxt;
  logic hit_r;
  logic [T_FRAC_BITS:0] t_r;

  always_comb begin
    lo = (tin_x > tin_y) ? tin_x : tin_y;
    hi = (tout_x < tout_y) ? tout_x : tout_y;
    hit_nxt = !ctl_x.miss && (tout_x >= tin_x) && !ctl_y.miss && (hi >= lo);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      t_r   <= hit_nxt ? lo : '0;
    end
  end

  assign out_valid   = vld_r[DEPTH-1];
  assign out_hit     = hit_r;
  assign out_entry_t = t_r;

`ifndef ASSERT_OFF
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_t <= ((T_FRAC_BITS+1)'(1) << T_FRAC_BITS))
    else $error("entry parameter above 1.0");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> out_entry_t == '0)
    else $error("miss carries a nonzero entry parameter");
  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stage is stalled");
`endif

endmodule

// ----- rtl/sbsi_div.sv -----
// Pipelined restoring divider: quo = floor((num << FRAC) / den), num <= den, den > 0.
// One quotient bit is resolved per stage.
module sbsi_div #(
  parameter int NUM_BITS = 18,
  parameter int FRAC     = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_BITS-1:0] num,
  input  logic [NUM_BITS-1:0] den,
  output logic [FRAC:0]       quo
);

  logic [NUM_BITS:0]   rem_r [FRAC+1];
  logic [NUM_BITS-1:0] den_r [FRAC+1];
  logic [FRAC:0]       q_r   [FRAC+1];

  // Stage 0: the integer bit is 1 only when num equals den.
  always_ff @(posedge clk) begin
    if (en) begin
      if (num >= den) begin
        rem_r[0] <= {1'b0, num - den};
        q_r[0]   <= {1'b1, {FRAC{1'b0}}};
      end else begin
        rem_r[0] <= {1'b0, num};
        q_r[0]   <= '0;
      end
      den_r[0] <= den;
    end
  end

  for (genvar g = 1; g <= FRAC; g++) begin : g_stage
    logic [NUM_BITS+1:0] sh;
    logic [NUM_BITS+1:0] df;
    assign sh = {rem_r[g-1], 1'b0};
    assign df = sh - {2'b00, den_r[g-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!df[NUM_BITS+1]) begin
          rem_r[g] <= df[NUM_BITS:0];
          q_r[g]   <= q_r[g-1] | ((FRAC+1)'(1) << (FRAC - g));
        end else begin
          rem_r[g] <= sh[NUM_BITS:0];
          q_r[g]   <= q_r[g-1];
        end
        den_r[g] <= den_r[g-1];
      end
    end
  end

  assign quo = q_r[FRAC];

endmodule

// ----- rtl/sbsi_axis.sv -----
// One slab axis: bounds, span tests and the entry and exit quotients.
// Flags are delayed alongside the dividers.
module sbsi_axis #(
  parameter int CB   = 16,
  parameter int HB   = 15,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CB-1:0] s,
  input  logic signed [CB-1:0] e,
  input  logic signed [CB-1:0] c,
  input  logic [HB-1:0]        h,
  output sbsi_pkg::axis_ctl_t  ctl,
  output logic [FRAC:0]        t_in,
  output logic [FRAC:0]        t_out
);

  localparam int WB = ((CB > HB) ? CB : HB) + 3;
  localparam int LAT = FRAC + 1;

  logic signed [WB-1:0] s_w, e_w, bmin, bmax;
  logic fwd;
  sbsi_pkg::axis_ctl_t ctl_nxt;
  logic [WB-1:0] n_in_nxt, n_out_nxt, den_nxt;

  assign s_w  = WB'(s);
  assign e_w  = WB'(e);
  assign bmin = WB'(c) - WB'(signed'({1'b0, h}));
  assign bmax = WB'(c) + WB'(signed'({1'b0, h}));
  assign fwd  = s_w < e_w;

  always_comb begin
    if (fwd) begin
      ctl_nxt.miss     = (s_w > bmax) || (e_w < bmin);
      ctl_nxt.need_in  = s_w < bmin;
      ctl_nxt.need_out = e_w > bmax;
      n_in_nxt  = WB'(bmin - s_w);
      n_out_nxt = WB'(bmax - s_w);
      den_nxt   = WB'(e_w - s_w);
    end else begin
      ctl_nxt.miss     = (e_w > bmax) || (s_w < bmin);
      ctl_nxt.need_in  = s_w > bmax;
      ctl_nxt.need_out = e_w < bmin;
      n_in_nxt  = WB'(s_w - bmax);
      n_out_nxt = WB'(s_w - bmin);
      den_nxt   = WB'(s_w - e_w);
    end
    // Keep the dividers in range when a quotient is not used.
    if (ctl_nxt.miss || !ctl_nxt.need_in) n_in_nxt = '0;
    if (ctl_nxt.miss || !ctl_nxt.need_out) n_out_nxt = '0;
    if (den_nxt == '0) den_nxt = WB'(1);
  end

  logic [WB-1:0] n_in_r, n_out_r, den_r;
  sbsi_pkg::axis_ctl_t ctl_r [LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_in_r   <= n_in_nxt;
      n_out_r  <= n_out_nxt;
      den_r    <= den_nxt;
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i <= LAT; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  logic [FRAC:0] q_in, q_out;

  sbsi_div #(.NUM_BITS(WB), .FRAC(FRAC)) u_div_in (
    .clk(clk), .en(en), .num(n_in_r), .den(den_r), .quo(q_in));
  sbsi_div #(.NUM_BITS(WB), .FRAC(FRAC)) u_div_out (
    .clk(clk), .en(en), .num(n_out_r), .den(den_r), .quo(q_out));

  assign ctl   = ctl_r[LAT];
  assign t_in  = ctl_r[LAT].need_in ? q_in : '0;
  assign t_out = ctl_r[LAT].need_out ? q_out : (FRAC+1)'(1) << FRAC;

endmodule

// ----- tb/segment_box_slab_intersect_tb.sv -----
`default_nettype none

// Checks every result of the slab intersection block against a predictor
// that works out, per segment and box, whether they meet and where the
// segment enters.
module segment_box_slab_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int LATENCY = FB + 3;
  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM = 1830;

  typedef struct {
    logic signed [CB-1:0] sx, sy, ex, ey, cx, cy;
    logic [14:0] hx, hy;
  } seg_box_t;

  typedef struct packed {
    logic          hit;
    logic [FB:0]   entry;
  } hit_t;

  // One row of the directed table. When typed is set, the expected result is
  // written in the row and is compared with the predictor as well.
  typedef struct {
    seg_box_t item;
    bit       typed;
    hit_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic signed [CB-1:0] in_box_center_x = '0, in_box_center_y = '0;
  logic [14:0] in_box_half_x = '0, in_box_half_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [FB:0] out_entry_t;

  hit_t expected_hits[$];
  int   errors = 0;
  bit   hold_out = 1'b0;
  bit   feeding_done = 1'b0;
  int   idle_cycles = 0;

  always #1 clk = ~clk;

  segment_box_slab_intersect dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .in_box_center_x, .in_box_center_y, .in_box_half_x, .in_box_half_y,
    .out_valid, .out_ready, .out_hit, .out_entry_t
  );

  // floor(num * 2^FB / den) with 0 <= num <= den and den > 0.
  function automatic longint unsigned q_frac(longint num, longint den);
    return (longint'(num) <<< FB) / den;
  endfunction

  // Narrows the running interval by one axis; returns 0 when the axis misses or the interval becomes empty.
  function automatic bit clip_axis(longint s, longint e, longint bmin, longint bmax,
                                   inout longint unsigned lo, inout longint unsigned hi);
    longint unsigned tin, tout;
    if (s < e) begin
      if (s > bmax || e < bmin) return 1'b0;
      tin  = (s < bmin) ? q_frac(bmin - s, e - s) : 0;
      tout = (e > bmax) ? q_frac(bmax - s, e - s) : (64'd1 << FB);
    end else begin
      if (e > bmax || s < bmin) return 1'b0;
      tin  = (s > bmax) ? q_frac(s - bmax, s - e) : 0;
      tout = (e < bmin) ? q_frac(s - bmin, s - e) : (64'd1 << FB);
    end
    if (tin > lo) lo = tin;
    if (tout < hi) hi = tout;
    return hi >= lo;
  endfunction

  function automatic hit_t predict_hit(seg_box_t it);
    longint unsigned lo, hi;
    bit ok;
    hit_t r;
    lo = 0;
    hi = 64'd1 << FB;
    ok = clip_axis(it.sx, it.ex, longint'(it.cx) - it.hx, longint'(it.cx) + it.hx, lo, hi);
    if (ok)
      ok = clip_axis(it.sy, it.ey, longint'(it.cy) - it.hy, longint'(it.cy) + it.hy, lo, hi);
    r.hit = ok;
    r.entry = ok ? lo[FB:0] : '0;
    return r;
  endfunction

  function automatic seg_box_t mk(int sx, int sy, int ex, int ey, int cx, int cy,
                                  int hx, int hy);
    seg_box_t it;
    it.sx = sx; it.sy = sy; it.ex = ex; it.ey = ey;
    it.cx = cx; it.cy = cy; it.hx = hx; it.hy = hy;
    return it;
  endfunction

  // Random coordinates: mostly near a box so both hits and misses occur,
  // sometimes fully random so every bit of every field toggles.
  function automatic seg_box_t rand_item();
    seg_box_t it;
    int span;
    it.cx = $urandom; it.cy = $urandom;
    it.hx = $urandom; it.hy = $urandom;
    it.sx = $urandom; it.sy = $urandom; it.ex = $urandom; it.ey = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      span = (1 << $urandom_range(2, 14));
      it.hx = $urandom_range(0, span);
      it.hy = $urandom_range(0, span);
      it.cx = $signed(16'($urandom_range(0, 65535))) >>> 2;
      it.cy = $signed(16'($urandom_range(0, 65535))) >>> 2;
      it.sx = it.cx + $signed(32'($urandom_range(0, 6 * span))) - 3 * span;
      it.sy = it.cy + $signed(32'($urandom_range(0, 6 * span))) - 3 * span;
      it.ex = it.cx + $signed(32'($urandom_range(0, 6 * span))) - 3 * span;
      it.ey = it.cy + $signed(32'($urandom_range(0, 6 * span))) - 3 * span;
      if ($urandom_range(0, 9) == 0) it.ex = it.sx;
      if ($urandom_range(0, 9) == 0) it.ey = it.sy;
    end
    return it;
  endfunction

  task automatic send_item(seg_box_t it);
    in_valid        <= 1'b1;
    in_start_x      <= it.sx;
    in_start_y      <= it.sy;
    in_end_x        <= it.ex;
    in_end_y        <= it.ey;
    in_box_center_x <= it.cx;
    in_box_center_y <= it.cy;
    in_box_half_x   <= it.hx;
    in_box_half_y   <= it.hy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hits.push_back(predict_hit(it));
  endtask

  // Sender: bursts of random length, gaps between them. The valid line is
  // only lowered in a gap or while draining, so no step sees it both lowered and raised.
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start inside the box: hit with entry zero.
    r.item = mk(0, 0, 100, 100, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b1, '0};
    rows.push_back(r);
    // Wholly outside on x: miss with entry zero.
    r.item = mk(100, 0, 200, 0, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b0, '0};
    rows.push_back(r);
    // Wholly outside on y only.
    r.item = mk(0, 100, 0, 200, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b0, '0};
    rows.push_back(r);
    // Enters halfway along x.
    r.item = mk(-20, 0, 0, 0, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b1, 17'h08000};
    rows.push_back(r);
    // Degenerate point inside and outside.
    r.item = mk(5, 5, 5, 5, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b1, '0};
    rows.push_back(r);
    r.item = mk(11, 5, 11, 5, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b0, '0};
    rows.push_back(r);
    // End exactly touching the box: entry is 1.0.
    r.item = mk(-20, 0, -10, 0, 0, 0, 10, 10); r.typed = 1; r.want = '{1'b1, 17'h10000};
    rows.push_back(r);
    // Extremes of every field.
    r.item = mk(-32768, -32768, 32767, 32767, 0, 0, 0, 0); r.typed = 0; rows.push_back(r);
    r.item = mk(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767); r.typed = 0;
    rows.push_back(r);
    r.item = mk(32767, -32768, -32768, 32767, 32767, 32767, 32767, 32767); r.typed = 0;
    rows.push_back(r);
    r.item = mk(-32768, 32767, 32767, -32768, 32767, -32768, 0, 32767); r.typed = 0;
    rows.push_back(r);
    // Diagonal through a zero-size box, reversed direction, corner grazes.
    r.item = mk(-10, -10, 10, 10, 0, 0, 0, 0); r.typed = 0; rows.push_back(r);
    r.item = mk(30, 30, -30, -30, 0, 0, 10, 10); r.typed = 0; rows.push_back(r);
    r.item = mk(-20, 0, 0, 20, 0, 0, 10, 10); r.typed = 0; rows.push_back(r);
    r.item = mk(-21, 0, 0, 21, 0, 0, 10, 10); r.typed = 0; rows.push_back(r);
    // Truncation tie: entry and exit round down to one code.
    r.item = mk(0, 0, 3, 3, 2, 1, 1, 0); r.typed = 0; rows.push_back(r);
    r.item = mk(0, 7, 7, 0, 3, 3, 0, 0); r.typed = 0; rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].typed && predict_hit(rows[i].item) != rows[i].want) begin
        $error("directed row %0d: predictor disagrees with table", i);
        errors++;
      end
      send_item(rows[i].item);
      maybe_gap();
    end
    // Pause until every expected result has come.
    wait_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_out = 1'b1;
      if (n == 900) wait_drained();
      send_item(rand_item());
      maybe_gap();
    end
    in_valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // Receiver: its own stall pattern, plus one long hold-off that fills the
  // pipeline so the block has to drop in_ready.
  initial begin
    int mode;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_out = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checking and the watchdog both sample at the rising edge.
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          errors++;
        end
        if (out_entry_t !== want.entry) begin
          $error("entry_t: expected %0d, got %0d", want.entry, out_entry_t);
          errors++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    wait (feeding_done);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/sbsi_pkg.sv
rtl/sbsi_div.sv
rtl/sbsi_axis.sv
rtl/segment_box_slab_intersect.sv
tb/segment_box_slab_intersect_tb.sv
